@@ rtl/tavsl_pkg.sv @@
// shared widths, types and register indexes for the three-axis velocity slew limiter
package tavsl_pkg;

  localparam int STICK_W  = 17;
  localparam int CFG_W    = 16;
  localparam int TIME_W   = 16;
  localparam int VEL_W    = 25;
  localparam int STEP_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] DEADZONE_RST     = 16'd3277;
  localparam logic [CFG_W-1:0] TOP_SPEED_RST    = 16'd256;
  localparam logic [CFG_W-1:0] ACCELERATION_RST = 16'd256;
  localparam logic [CFG_W-1:0] DECELERATION_RST = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE     = 2'd0,
    CFG_TOP_SPEED    = 2'd1,
    CFG_ACCELERATION = 2'd2,
    CFG_DECELERATION = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic                    stop;
    logic signed [VEL_W-1:0] target_forward;
    logic signed [VEL_W-1:0] target_strafe;
    logic signed [VEL_W-1:0] target_turn;
    logic [STEP_W-1:0]       step_acc;
    logic [STEP_W-1:0]       step_dec;
  } tick_t;

endpackage

@@ rtl/three_axis_velocity_slew_limiter.sv @@
// top level of the three-axis velocity slew limiter
// Takes one tick transaction per clock and returns one velocity transaction per tick, in order.
// A tick's result is held in the queue and then the output register; the front end computes
// targets and step sizes combinationally as the tick is accepted and writes them into a
// four-entry queue, and the back end slews the three held velocities, one queue entry per
// cycle while the output is not stalled. The input stalls only while that queue is full.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_data and take effect
// for ticks accepted afterwards; write them only while the block is idle.
module three_axis_velocity_slew_limiter
  import tavsl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic signed [STICK_W-1:0] stick_forward,
  input  logic signed [STICK_W-1:0] stick_strafe,
  input  logic signed [STICK_W-1:0] stick_turn,
  input  logic [TIME_W-1:0]         tick_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VEL_W-1:0]   velocity_forward,
  output logic signed [VEL_W-1:0]   velocity_strafe,
  output logic signed [VEL_W-1:0]   velocity_turn
);

  tick_t tick;
  tick_t head;
  logic  full;
  logic  nonempty;
  logic  pop;
  logic  push;

  assign in_stall = full;
  assign push     = in_valid && !full;

  tavsl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .stick_forward (stick_forward),
    .stick_strafe  (stick_strafe),
    .stick_turn    (stick_turn),
    .tick_time     (tick_time),
    .tick          (tick)
  );

  tavsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (tick),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  tavsl_back u_back (
    .clk              (clk),
    .rst              (rst),
    .nonempty         (nonempty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .velocity_forward (velocity_forward),
    .velocity_strafe  (velocity_strafe),
    .velocity_turn    (velocity_turn)
  );

endmodule

@@ rtl/tavsl_front.sv @@
// front end: configuration registers, stick clamp and deadzone, target and step products
module tavsl_front
  import tavsl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      kind,
  input  logic signed [STICK_W-1:0] stick_forward,
  input  logic signed [STICK_W-1:0] stick_strafe,
  input  logic signed [STICK_W-1:0] stick_turn,
  input  logic [TIME_W-1:0]         tick_time,
  output tick_t                     tick
);

  localparam logic signed [STICK_W-1:0] FULL_POS = STICK_W'(32768);
  localparam logic signed [STICK_W-1:0] FULL_NEG = -STICK_W'(32768);

  logic [CFG_W-1:0] deadzone;
  logic [CFG_W-1:0] top_speed;
  logic [CFG_W-1:0] acceleration;
  logic [CFG_W-1:0] deceleration;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone     <= DEADZONE_RST;
      top_speed    <= TOP_SPEED_RST;
      acceleration <= ACCELERATION_RST;
      deceleration <= DECELERATION_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEADZONE:     deadzone     <= cfg_data;
        CFG_TOP_SPEED:    top_speed    <= cfg_data;
        CFG_ACCELERATION: acceleration <= cfg_data;
        CFG_DECELERATION: deceleration <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [VEL_W-1:0] target_of(
    input logic signed [STICK_W-1:0] d,
    input logic [CFG_W-1:0]          dz,
    input logic [CFG_W-1:0]          vmax
  );
    logic signed [STICK_W-1:0] dc;
    logic [STICK_W-1:0]        a;
    logic [STICK_W+CFG_W-1:0]  prod;
    logic signed [VEL_W-1:0]   t;
    if (d > FULL_POS) begin
      dc = FULL_POS;
    end else if (d < FULL_NEG) begin
      dc = FULL_NEG;
    end else begin
      dc = d;
    end
    a    = dc[STICK_W-1] ? STICK_W'(-dc) : STICK_W'(dc);
    prod = (STICK_W+CFG_W)'(a) * (STICK_W+CFG_W)'(vmax);
    t    = signed'({1'b0, prod[STEP_W+6:7]});
    if (a < {1'b0, dz}) begin
      target_of = '0;
    end else if (dc[STICK_W-1]) begin
      target_of = -t;
    end else begin
      target_of = t;
    end
  endfunction

  logic [CFG_W+TIME_W-1:0] prod_acc;
  logic [CFG_W+TIME_W-1:0] prod_dec;

  always_comb begin
    prod_acc = (CFG_W+TIME_W)'(acceleration) * (CFG_W+TIME_W)'(tick_time);
    prod_dec = (CFG_W+TIME_W)'(deceleration) * (CFG_W+TIME_W)'(tick_time);
    tick.stop           = kind;
    tick.target_forward = target_of(stick_forward, deadzone, top_speed);
    tick.target_strafe  = target_of(stick_strafe, deadzone, top_speed);
    tick.target_turn    = target_of(stick_turn, deadzone, top_speed);
    tick.step_acc       = prod_acc[STEP_W+7:8];
    tick.step_dec       = prod_dec[STEP_W+7:8];
  end

endmodule

@@ rtl/tavsl_queue.sv @@
// short queue of classified ticks between front and back end
module tavsl_queue
  import tavsl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  tick_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output tick_t head
);

  tick_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tavsl_back.sv @@
// back end: per-axis slew toward target, held velocities and output register
module tavsl_back
  import tavsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    nonempty,
  input  tick_t                   head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VEL_W-1:0] velocity_forward,
  output logic signed [VEL_W-1:0] velocity_strafe,
  output logic signed [VEL_W-1:0] velocity_turn
);

  function automatic logic signed [VEL_W-1:0] ramp(
    input logic signed [VEL_W-1:0] cur,
    input logic signed [VEL_W-1:0] tgt,
    input logic [STEP_W-1:0]       sa,
    input logic [STEP_W-1:0]       sd
  );
    logic [VEL_W-1:0]        mc;
    logic [VEL_W-1:0]        mt;
    logic                    slowing;
    logic [STEP_W-1:0]       step;
    logic signed [VEL_W:0]   err;
    logic [VEL_W:0]          merr;
    logic signed [VEL_W-1:0] sstep;
    mc      = cur[VEL_W-1] ? VEL_W'(-cur) : VEL_W'(cur);
    mt      = tgt[VEL_W-1] ? VEL_W'(-tgt) : VEL_W'(tgt);
    slowing = (mt < mc) || (tgt < 0 && cur > 0) || (tgt > 0 && cur < 0);
    step    = slowing ? sd : sa;
    sstep   = signed'({1'b0, step});
    err     = signed'({tgt[VEL_W-1], tgt}) - signed'({cur[VEL_W-1], cur});
    merr    = err[VEL_W] ? (VEL_W+1)'(-err) : (VEL_W+1)'(err);
    if (merr <= {2'b00, step}) begin
      ramp = tgt;
    end else if (err[VEL_W]) begin
      ramp = cur - sstep;
    end else begin
      ramp = cur + sstep;
    end
  endfunction

  logic signed [VEL_W-1:0] forward_next;
  logic signed [VEL_W-1:0] strafe_next;
  logic signed [VEL_W-1:0] turn_next;

  assign pop = nonempty && (!out_valid || !out_stall);

  always_comb begin
    if (head.stop) begin
      forward_next = '0;
      strafe_next  = '0;
      turn_next    = '0;
    end else begin
      forward_next = ramp(velocity_forward, head.target_forward, head.step_acc, head.step_dec);
      strafe_next  = ramp(velocity_strafe, head.target_strafe, head.step_acc, head.step_dec);
      turn_next    = ramp(velocity_turn, head.target_turn, head.step_acc, head.step_dec);
    end
  end

  // output register doubles as the held velocity state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      velocity_forward <= '0;
      velocity_strafe  <= '0;
      velocity_turn    <= '0;
    end else if (pop) begin
      out_valid        <= 1'b1;
      velocity_forward <= forward_next;
      velocity_strafe  <= strafe_next;
      velocity_turn    <= turn_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
